FILE: hw/rtl/fwsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fwsc_pkg;

    localparam int FRAME_W = 31;
    localparam int KEY_W   = 32;
    localparam int LEFT_W  = 5;
    localparam int RIGHT_W = 4;
    localparam int BOUND_W = 34;
    localparam int SLOT_W  = 4;

    localparam logic [1:0] OP_CACHE   = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_SET_KEY = 2'd2;

    localparam logic CFG_WINDOW_LEFT  = 1'b0;
    localparam logic CFG_WINDOW_RIGHT = 1'b1;

    localparam logic signed [KEY_W-1:0]   KEY_RESET   = -32'sd1;
    localparam logic signed [LEFT_W-1:0]  LEFT_RESET  = -5'sd7;
    localparam logic        [RIGHT_W-1:0] RIGHT_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [FRAME_W-1:0]       frame_number;
        logic signed [KEY_W-1:0]  new_key_frame;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot_index;
        logic              was_hit;
    } rsp_t;

    typedef struct packed {
        logic match;
        logic stale;
    } cmp_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fwsc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fwsc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fwsc_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

// one slot against the requested frame and the window bounds
module fwsc_cmp (
    input  wire logic                                  entry_vld,
    input  wire logic [fwsc_pkg::FRAME_W-1:0]          entry_frame,
    input  wire logic [fwsc_pkg::FRAME_W-1:0]          frame,
    input  wire logic signed [fwsc_pkg::BOUND_W-1:0]   lo,
    input  wire logic signed [fwsc_pkg::BOUND_W-1:0]   hi,
    output fwsc_pkg::cmp_res_t                         res
);

    logic signed [fwsc_pkg::BOUND_W-1:0] entry_ext;

    assign entry_ext = $signed({{(fwsc_pkg::BOUND_W - fwsc_pkg::FRAME_W){1'b0}}, entry_frame});

    always_comb
    begin
        res.match = entry_vld && (entry_frame == frame);
        // empty slots count as stale
        res.stale = !entry_vld || (entry_ext < lo) || (entry_ext > hi);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/frame_window_slot_cache_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+--------------------------------
// in        | in        | in_valid/in_stall  | in_data  (opcode, frame, key)
// out       | out       | out_valid/out_stall| out_data (status, slot, hit)
// cfg       | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// cache and lookup: the scan state reads one slot per cycle through the slot ram read port
// into one shared compare unit, then the finish state registers the result; the result
// is valid in the same cycle as the sequencer is back in idle and takes the next request
// set key and unused opcodes: skip the scan and go from idle straight to the finish state
// reset empties every slot at once through per-slot valid bits, no clearing pass
// a stalled output holds the next result in the finish state; in_stall stays high
module frame_window_slot_cache_core #(
    parameter int SLOTS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire fwsc_pkg::req_t                      in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output fwsc_pkg::rsp_t                           out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [fwsc_pkg::LEFT_W-1:0]         cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] CNT_END = CW'(SLOTS);

    fwsc_pkg::state_t state_reg, state_next;

    logic signed [fwsc_pkg::LEFT_W-1:0]   left_reg;
    logic        [fwsc_pkg::RIGHT_W-1:0]  right_reg;
    logic signed [fwsc_pkg::KEY_W-1:0]    key_reg;
    logic signed [fwsc_pkg::BOUND_W-1:0]  lo_reg, hi_reg;
    logic [1:0]                           op_reg;
    logic [fwsc_pkg::FRAME_W-1:0]         frame_reg;

    logic [SLOTS-1:0] vld_reg;
    logic [CW-1:0]    cnt_reg;
    logic             pend_reg;
    logic [IW-1:0]    pidx_reg;
    logic             hit_found_reg, stale_found_reg;
    logic [IW-1:0]    hit_idx_reg, stale_idx_reg;

    logic                      out_valid_reg;
    fwsc_pkg::rsp_t            out_data_reg;
    fwsc_pkg::rsp_t            rsp_next;

    logic                         accept;
    logic                         issue;
    logic                         scan_done;
    logic                         load_out;
    logic                         ram_we;
    logic [fwsc_pkg::FRAME_W-1:0] ram_rdata;
    fwsc_pkg::cmp_res_t           cmp_res;

    assign accept    = in_valid && !in_stall;
    assign issue     = (state_reg == fwsc_pkg::ST_SCAN) && (cnt_reg != CNT_END);
    assign scan_done = (cnt_reg == CNT_END) && !pend_reg;
    assign load_out  = (state_reg == fwsc_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    fwsc_ram #(
        .WIDTH (fwsc_pkg::FRAME_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (stale_idx_reg),
        .wdata (frame_reg),
        .re    (issue),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    fwsc_cmp u_cmp (
        .entry_vld   (vld_reg[pidx_reg]),
        .entry_frame (ram_rdata),
        .frame       (frame_reg),
        .lo          (lo_reg),
        .hi          (hi_reg),
        .res         (cmp_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fwsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.opcode == fwsc_pkg::OP_CACHE ||
                        in_data.opcode == fwsc_pkg::OP_LOOKUP)
                    begin
                        state_next = fwsc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = fwsc_pkg::ST_FINISH;
                    end
                end
            end
            fwsc_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = fwsc_pkg::ST_FINISH;
                end
            end
            fwsc_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = fwsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwsc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall = (state_reg != fwsc_pkg::ST_IDLE);
        ram_we   = 1'b0;
        rsp_next = '{status: 1'b1, slot_index: '0, was_hit: 1'b0};
        case (op_reg)
            fwsc_pkg::OP_CACHE:
            begin
                if (hit_found_reg)
                begin
                    rsp_next = '{status: 1'b0, slot_index: fwsc_pkg::SLOT_W'(hit_idx_reg),
                                 was_hit: 1'b1};
                end
                else if (stale_found_reg)
                begin
                    rsp_next = '{status: 1'b0, slot_index: fwsc_pkg::SLOT_W'(stale_idx_reg),
                                 was_hit: 1'b0};
                    ram_we   = load_out;
                end
            end
            fwsc_pkg::OP_LOOKUP:
            begin
                if (hit_found_reg)
                begin
                    rsp_next = '{status: 1'b0, slot_index: fwsc_pkg::SLOT_W'(hit_idx_reg),
                                 was_hit: 1'b1};
                end
            end
            fwsc_pkg::OP_SET_KEY:
            begin
                rsp_next = '{status: 1'b0, slot_index: '0, was_hit: 1'b0};
            end
            default:
            begin
                rsp_next = '{status: 1'b1, slot_index: '0, was_hit: 1'b0};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fwsc_pkg::ST_IDLE;
            left_reg        <= fwsc_pkg::LEFT_RESET;
            right_reg       <= fwsc_pkg::RIGHT_RESET;
            key_reg         <= fwsc_pkg::KEY_RESET;
            vld_reg         <= '0;
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            hit_found_reg   <= 1'b0;
            stale_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    fwsc_pkg::CFG_WINDOW_LEFT:  left_reg  <= $signed(cfg_data);
                    fwsc_pkg::CFG_WINDOW_RIGHT: right_reg <= cfg_data[fwsc_pkg::RIGHT_W-1:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                cnt_reg         <= '0;
                pend_reg        <= 1'b0;
                hit_found_reg   <= 1'b0;
                stale_found_reg <= 1'b0;
                if (in_data.opcode == fwsc_pkg::OP_SET_KEY)
                begin
                    key_reg <= in_data.new_key_frame;
                end
            end
            else if (state_reg == fwsc_pkg::ST_SCAN)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                // first match and first stale slot, lowest index wins
                if (pend_reg && cmp_res.match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (pend_reg && cmp_res.stale && !stale_found_reg)
                begin
                    stale_found_reg <= 1'b1;
                end
            end

            if (ram_we)
            begin
                vld_reg[stale_idx_reg] <= 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_data.opcode;
            frame_reg <= in_data.frame_number;
            lo_reg    <= fwsc_pkg::BOUND_W'(key_reg) + fwsc_pkg::BOUND_W'(left_reg);
            hi_reg    <= fwsc_pkg::BOUND_W'(key_reg)
                         + $signed({{(fwsc_pkg::BOUND_W - fwsc_pkg::RIGHT_W){1'b0}}, right_reg});
        end
        if (issue)
        begin
            pidx_reg <= cnt_reg[IW-1:0];
        end
        if (state_reg == fwsc_pkg::ST_SCAN && pend_reg)
        begin
            if (cmp_res.match && !hit_found_reg)
            begin
                hit_idx_reg <= pidx_reg;
            end
            if (cmp_res.stale && !stale_found_reg)
            begin
                stale_idx_reg <= pidx_reg;
            end
        end
        if (load_out)
        begin
            out_data_reg <= rsp_next;
        end
    end

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fwsc_pkg::ST_SCAN) |-> (cnt_reg <= CNT_END))
        else $error("scan counter beyond slot count");

    a_claim_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!hit_found_reg && stale_found_reg && op_reg == fwsc_pkg::OP_CACHE))
        else $error("slot claimed without a stale slot or despite a hit");

    a_claim_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> vld_reg[$past(stale_idx_reg)])
        else $error("claimed slot not marked valid");

    a_hit_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && rsp_next.was_hit) |-> !rsp_next.status)
        else $error("hit reported with failure status");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != fwsc_pkg::ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire
